// ----- rtl/window_level_gray_map_top_macros.svh -----
// Assertion macros for the window/level gray mapper.
`ifndef WINDOW_LEVEL_GRAY_MAP_TOP_MACROS_SVH
`define WINDOW_LEVEL_GRAY_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define WLGM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wlgm implication check failed");
`define WLGM_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("wlgm forbidden condition seen");
`else
`define WLGM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define WLGM_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

// ----- rtl/wlgm_pkg.sv -----
// Shared constants and types for the window/level gray mapper.
package wlgm_pkg;

  localparam int PIXEL_BITS     = 16;
  localparam int WORD_BITS      = 16;
  localparam int GRAY_BITS      = 8;
  localparam int REM_BITS       = PIXEL_BITS + GRAY_BITS;
  localparam int CFG_INDEX_BITS = 8;

  localparam logic [WORD_BITS-1:0] WINDOW_LOW_RESET  = WORD_BITS'(0);
  localparam logic [WORD_BITS-1:0] WINDOW_HIGH_RESET = WORD_BITS'(1000);
  localparam logic [GRAY_BITS-1:0] GRAY_MAX          = '1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WINDOW_LOW  = CFG_INDEX_BITS'(0),
    REG_WINDOW_HIGH = CFG_INDEX_BITS'(1)
  } cfg_reg_t;

  typedef struct packed {
    logic sat_high;
    logic sat_low;
  } wlgm_flags_t;

  typedef struct packed {
    logic [REM_BITS-1:0]   rem;
    logic [PIXEL_BITS-1:0] den;
    logic [GRAY_BITS-1:0]  quo;
    wlgm_flags_t           flags;
  } wlgm_div_t;

endpackage

// ----- rtl/window_level_gray_map_top.sv -----
// Top level: window/level mapping of detector pixels to 8-bit gray.
//
//   channel   direction  payload
//   s_axis    in         tdata[15:0] pixel_in
//   m_axis    out        tdata[7:0]  gray_out
//   cfg       in         cfg_index, cfg_data[15:0]
//
// One pixel per clock sustained while m_axis_tready holds; 2 front stages, 8 divide steps.
// Each stage has its own valid bit and local ready, so bubbles close up under stall.
// rst is synchronous: clears valid bits, window_low to 0, window_high to 1000.
// cfg_ready is always high; write the window only while the pipe is empty.
`include "window_level_gray_map_top_macros.svh"

module window_level_gray_map_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [wlgm_pkg::WORD_BITS-1:0]    s_axis_tdata,   // [15:0] pixel_in
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [wlgm_pkg::GRAY_BITS-1:0]    m_axis_tdata,   // [7:0] gray_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wlgm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wlgm_pkg::WORD_BITS-1:0]    cfg_data
);
  import wlgm_pkg::*;

  logic [WORD_BITS-1:0] window_low, window_high;
  logic [GRAY_BITS:0]   link_valid, link_ready;
  wlgm_div_t            link_data [GRAY_BITS+1];
  wlgm_div_t            last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= WINDOW_LOW_RESET;
      window_high <= WINDOW_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LOW:  window_low  <= cfg_data;
        REG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  wlgm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .pixel       (s_axis_tdata),
    .window_low  (window_low),
    .window_high (window_high),
    .out_valid   (link_valid[0]),
    .out_ready   (link_ready[0]),
    .out_data    (link_data[0])
  );

  for (genvar i = 0; i < GRAY_BITS; i++) begin : g_div
    wlgm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (link_valid[i]),
      .in_ready  (link_ready[i]),
      .in_data   (link_data[i]),
      .out_valid (link_valid[i+1]),
      .out_ready (link_ready[i+1]),
      .out_data  (link_data[i+1])
    );
  end

  assign last                  = link_data[GRAY_BITS];
  assign link_ready[GRAY_BITS] = m_axis_tready;
  assign m_axis_tvalid         = link_valid[GRAY_BITS];

  always_comb begin
    if (last.flags.sat_high) begin
      m_axis_tdata = GRAY_MAX;
    end else if (last.flags.sat_low) begin
      m_axis_tdata = '0;
    end else begin
      m_axis_tdata = last.quo;
    end
  end

  // input only stalls when a finished word is held at the output
  `WLGM_ASSERT_NEVER(a_stall_needs_output, clk, rst, !s_axis_tready && !m_axis_tvalid)
  // an in-window pixel always has a nonzero divisor
  `WLGM_ASSERT_IMPLIES(a_den_nonzero, clk, rst, m_axis_tvalid && !last.flags.sat_high && !last.flags.sat_low, last.den != '0)
  // final remainder (doubled) stays below twice the aligned divisor
  `WLGM_ASSERT_IMPLIES(a_rem_bound, clk, rst, m_axis_tvalid && !last.flags.sat_high && !last.flags.sat_low, last.rem < REM_BITS'({last.den, GRAY_BITS'(0)}))

endmodule

// ----- rtl/wlgm_front.sv -----
// Front stages: window compare and offset, then scale by 255.
module wlgm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [wlgm_pkg::WORD_BITS-1:0] pixel,
  input  logic [wlgm_pkg::WORD_BITS-1:0] window_low,
  input  logic [wlgm_pkg::WORD_BITS-1:0] window_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output wlgm_pkg::wlgm_div_t         out_data
);
  import wlgm_pkg::*;

  logic [PIXEL_BITS-1:0] p, lo, hi;
  logic                  a_valid, a_ready;
  logic [PIXEL_BITS-1:0] a_diff, a_den;
  wlgm_flags_t           a_flags;
  logic                  b_valid, b_ready;
  wlgm_div_t             b_data;

  assign p  = pixel[PIXEL_BITS-1:0];
  assign lo = window_low[PIXEL_BITS-1:0];
  assign hi = window_high[PIXEL_BITS-1:0];

  assign b_ready  = !b_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_valid;
    end
    if (a_ready && in_valid) begin
      a_diff           <= p - lo;
      a_den            <= hi - lo;
      a_flags.sat_high <= (p >= hi);
      a_flags.sat_low  <= (p < lo);
    end
  end

  // 255 * d as (d << 8) - d
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
    if (b_ready && a_valid) begin
      b_data.rem   <= REM_BITS'({a_diff, GRAY_BITS'(0)}) - REM_BITS'(a_diff);
      b_data.den   <= a_den;
      b_data.quo   <= '0;
      b_data.flags <= a_flags;
    end
  end

  assign out_valid = b_valid;
  assign out_data  = b_data;

endmodule

// ----- rtl/wlgm_div_step.sv -----
// One restoring-division step: one quotient bit per stage.
module wlgm_div_step (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wlgm_pkg::wlgm_div_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wlgm_pkg::wlgm_div_t out_data
);
  import wlgm_pkg::*;

  logic [REM_BITS-1:0] dsh;
  logic [REM_BITS-1:0] rem_sub;
  logic                ge;
  logic                valid;
  wlgm_div_t           data;

  // divisor aligned to the top quotient bit; remainder doubles each step
  assign dsh     = REM_BITS'({in_data.den, (GRAY_BITS-1)'(0)});
  assign ge      = (in_data.rem >= dsh);
  assign rem_sub = ge ? (in_data.rem - dsh) : in_data.rem;

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      data.rem   <= {rem_sub[REM_BITS-2:0], 1'b0};
      data.den   <= in_data.den;
      data.quo   <= {in_data.quo[GRAY_BITS-2:0], ge};
      data.flags <= in_data.flags;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

endmodule
